/* hw/rtl/rfr_pkg.sv */
// ---------------------------------------------------------------------------
// rfr_pkg: shared types and constants for the radar frame reassembler
// Store size, opcode and status codes, and the records that pass between
// the control, store and output queue modules.
// ---------------------------------------------------------------------------
`default_nettype none
package rfr_pkg;

    // Frame store size in bytes and the widths that follow from it
    localparam int unsigned MAX_FRAME_BYTES = 4194304;
    localparam int unsigned ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam int unsigned OFF_W  = $clog2(MAX_FRAME_BYTES + 1);

    // Fixed field widths
    localparam int unsigned LEN_W   = 23;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned RADDR_W = 22;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;

    // Widths for the length sum and the minimum-length compare
    localparam int unsigned CMP_W = (OFF_W > LEN_W) ? OFF_W : LEN_W;
    localparam int unsigned SUM_W = CMP_W + 1;

    localparam logic [ID_W-1:0]  START_MAGIC = 32'h00BE0001;
    localparam logic [ID_W-1:0]  BOTH_MAGIC  = 32'hEFBE0001;
    localparam logic [ID_W-1:0]  END_MAGIC   = 32'hEF000001;
    localparam logic [ID_W-1:0]  ID_NONE     = 32'hFFFFFFFF;
    localparam logic [LEN_W-1:0] MIN_RESET   = 23'd3000000;

    // Output queue depth
    localparam int unsigned QDEPTH = 3;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OP_PACKET   = 3'd0,
        OP_FRAGMENT = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_RESET    = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_NONE       = 3'd0,
        ST_READY      = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_TOO_SMALL  = 3'd4
    } status_t;

    // Store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // Store read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    // Result of one item before the store byte is merged in
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   rid;
        logic [LEN_W-1:0]  flen;
        logic              use_rdata;
    } res_t;

    // One finished result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   rid;
        logic [LEN_W-1:0]  flen;
        logic [BYTE_W-1:0] rdata;
    } out_word_t;

endpackage
`default_nettype wire

/* hw/rtl/rfr_store.sv */
// ---------------------------------------------------------------------------
// rfr_store: frame byte store
// Single-port-per-direction byte memory: one write and one registered read
// per cycle. Contents are not cleared at reset.
// ---------------------------------------------------------------------------
`default_nettype none
module rfr_store (
    input  wire logic                         aclk,
    input  wire rfr_pkg::wr_req_t             wr,
    input  wire rfr_pkg::rd_req_t             rd,
    output logic [rfr_pkg::BYTE_W-1:0]        rd_data
);

    logic [rfr_pkg::BYTE_W-1:0] mem [rfr_pkg::MAX_FRAME_BYTES];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rfr_ctrl.sv */
// ---------------------------------------------------------------------------
// rfr_ctrl: frame collection control
// Holds the collecting flag, write offset, frame id and minimum length,
// updates them for each accepted word, issues store accesses and registers
// the result while the store read completes.
// ---------------------------------------------------------------------------
`default_nettype none
module rfr_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rfr_pkg::LEN_W-1:0]     cfg_wr_data,
    input  wire logic                          in_take,
    input  wire logic [2:0]                    opcode,
    input  wire logic [rfr_pkg::ID_W-1:0]      magic,
    input  wire logic [rfr_pkg::ID_W-1:0]      frame_id,
    input  wire logic [rfr_pkg::LEN_W-1:0]     packet_len,
    input  wire logic [rfr_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                          byte_valid,
    input  wire logic                          first_beat,
    input  wire logic                          last_beat,
    input  wire logic [rfr_pkg::RADDR_W-1:0]   read_address,
    output rfr_pkg::wr_req_t                   wr,
    output rfr_pkg::rd_req_t                   rd,
    output logic                               res_valid_reg,
    output rfr_pkg::res_t                      res_reg
);

    logic                           collecting_reg, collecting_next;
    logic [rfr_pkg::OFF_W-1:0]      offset_reg, offset_next;
    logic [rfr_pkg::ID_W-1:0]       cur_id_reg, cur_id_next;
    logic                           accepting_reg, accepting_next;
    logic [rfr_pkg::LEN_W-1:0]      min_reg;
    rfr_pkg::res_t                  res_next;

    // Does a packet of the given length fit behind the given offset
    function automatic logic fits(input logic [rfr_pkg::OFF_W-1:0] off,
                                  input logic [rfr_pkg::LEN_W-1:0] len);
        logic [rfr_pkg::SUM_W-1:0] sum;
        sum = rfr_pkg::SUM_W'(off) + rfr_pkg::SUM_W'(len);
        return sum <= rfr_pkg::SUM_W'(rfr_pkg::MAX_FRAME_BYTES);
    endfunction

    // Next state, store access and result for the word on the input
    always_comb begin
        logic is_start;
        logic is_end;
        logic coll;
        logic acc;
        logic [rfr_pkg::OFF_W-1:0] off;
        logic [rfr_pkg::ID_W-1:0]  cid;
        logic do_append;
        logic long_enough;
        logic [rfr_pkg::CMP_W-1:0] off_c;
        logic [rfr_pkg::CMP_W-1:0] min_c;

        is_start = (magic == rfr_pkg::START_MAGIC) || (magic == rfr_pkg::BOTH_MAGIC);
        is_end   = (magic == rfr_pkg::END_MAGIC)   || (magic == rfr_pkg::BOTH_MAGIC);
        coll     = collecting_reg;
        acc      = accepting_reg;
        off      = offset_reg;
        cid      = cur_id_reg;
        do_append   = 1'b0;
        long_enough = 1'b0;
        off_c    = '0;
        min_c    = rfr_pkg::CMP_W'(min_reg);

        res_next           = '0;
        res_next.status    = rfr_pkg::ST_NONE;
        wr                 = '0;
        wr.data            = data_byte;
        rd                 = '0;
        rd.addr            = rfr_pkg::ADDR_W'(read_address);

        unique case (opcode)
            rfr_pkg::OP_PACKET, rfr_pkg::OP_FRAGMENT: begin
                // Start of a packet or fragment: decide whether to accept it
                if (first_beat) begin
                    if (opcode == rfr_pkg::OP_FRAGMENT) begin
                        acc = coll && fits(off, packet_len);
                    end else begin
                        acc = 1'b0;
                        if (is_start) begin
                            if (coll && (cid != frame_id)) begin
                                res_next.status = rfr_pkg::ST_INCOMPLETE;
                                res_next.rid    = cid;
                            end
                            off  = '0;
                            cid  = frame_id;
                            coll = 1'b1;
                        end
                        if (coll && (frame_id == cid)) begin
                            if (fits(off, packet_len)) begin
                                acc = 1'b1;
                            end else begin
                                coll            = 1'b0;
                                res_next.status = rfr_pkg::ST_OVERFLOW;
                                res_next.rid    = frame_id;
                            end
                        end
                    end
                end
                // Append the byte while below the store end
                do_append = acc && byte_valid &&
                            (rfr_pkg::SUM_W'(off) < rfr_pkg::SUM_W'(rfr_pkg::MAX_FRAME_BYTES));
                wr.en   = in_take && do_append;
                wr.addr = rfr_pkg::ADDR_W'(off);
                off_c   = rfr_pkg::CMP_W'(off);
                long_enough = do_append ? (off_c >= min_c) : (off_c > min_c);
                if (do_append) begin
                    off = off + 1'b1;
                end
                // Close the frame on an end magic
                if (last_beat) begin
                    if ((opcode == rfr_pkg::OP_PACKET) && acc && coll && is_end) begin
                        res_next.status = long_enough ? rfr_pkg::ST_READY
                                                      : rfr_pkg::ST_TOO_SMALL;
                        res_next.rid    = cid;
                        res_next.flen   = rfr_pkg::LEN_W'(off);
                        off  = '0;
                        cid  = rfr_pkg::ID_NONE;
                        coll = 1'b0;
                    end
                    acc = 1'b0;
                end
            end
            rfr_pkg::OP_FLUSH: begin
                // Deliver a long enough frame, then clear
                off_c = rfr_pkg::CMP_W'(off);
                if (coll && (off_c > min_c)) begin
                    res_next.status = rfr_pkg::ST_READY;
                    res_next.rid    = cid;
                    res_next.flen   = rfr_pkg::LEN_W'(off);
                end
                off  = '0;
                cid  = rfr_pkg::ID_NONE;
                coll = 1'b0;
                acc  = 1'b0;
            end
            rfr_pkg::OP_RESET: begin
                off  = '0;
                cid  = rfr_pkg::ID_NONE;
                coll = 1'b0;
                acc  = 1'b0;
            end
            rfr_pkg::OP_READ: begin
                // Read the store; addresses past the end give zero
                if (32'(read_address) < 32'(rfr_pkg::MAX_FRAME_BYTES)) begin
                    rd.en              = in_take;
                    res_next.use_rdata = 1'b1;
                end
            end
            default: begin
            end
        endcase

        collecting_next = coll;
        offset_next     = off;
        cur_id_next     = cid;
        accepting_next  = acc;
    end

    // Frame state and minimum length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            offset_reg     <= '0;
            cur_id_reg     <= rfr_pkg::ID_NONE;
            accepting_reg  <= 1'b0;
            min_reg        <= rfr_pkg::MIN_RESET;
        end else begin
            if (in_take) begin
                collecting_reg <= collecting_next;
                offset_reg     <= offset_next;
                cur_id_reg     <= cur_id_next;
                accepting_reg  <= accepting_next;
            end
            if (cfg_wr_en) begin
                min_reg <= cfg_wr_data;
            end
        end
    end

    // Register the result, aligned with the store read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= in_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rfr_outq.sv */
// ---------------------------------------------------------------------------
// rfr_outq: result queue
// Small queue between the result stage and the output channel. Room is
// reserved for the word in flight, so the input side never waits on the
// output handshake combinationally.
// ---------------------------------------------------------------------------
`default_nettype none
module rfr_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire rfr_pkg::out_word_t  push_word,
    output logic                     room,
    output logic                     pop_valid,
    output rfr_pkg::out_word_t       pop_word,
    input  wire logic                pop_ready
);

    rfr_pkg::out_word_t              q_mem [rfr_pkg::QDEPTH];
    logic [rfr_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rfr_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rfr_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            pop;

    function automatic logic [rfr_pkg::QPTR_W-1:0] bump(
        input logic [rfr_pkg::QPTR_W-1:0] p);
        logic [rfr_pkg::QPTR_W-1:0] n;
        if (p == rfr_pkg::QPTR_W'(rfr_pkg::QDEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    // Accept a new word only if the queue has room for it and the one in flight
    assign room      = (rfr_pkg::QCNT_W'(count_reg) + rfr_pkg::QCNT_W'(push))
                       < rfr_pkg::QCNT_W'(rfr_pkg::QDEPTH);
    assign pop_valid = (count_reg != '0);
    assign pop_word  = q_mem[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + rfr_pkg::QCNT_W'(push) - rfr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/radar_frame_reassembler.sv */
// Result path: a result word passes the rfr_ctrl result register, then the result queue.
// Throughput: one word per cycle; the frame store takes one write and one read per cycle.
// s_axis_tready drops only when the three-entry result queue cannot take another word.
// Reset: collection state cleared, frame id set to all ones, min_frame_bytes to 3000000;
// the frame store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// radar_frame_reassembler: top level
// Rebuilds radar frames from payload bytes into a byte store, reports frame
// ready, drop and too-small events and reads the store back on request.
// ---------------------------------------------------------------------------
`default_nettype none
module radar_frame_reassembler (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Minimum frame length register
    input  wire logic          cfg_wr_en,
    input  wire logic [22:0]   cfg_wr_data,
    // Input words
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // magic[31:0], frame_id[63:32], packet_len[86:64], data_byte[94:87],
    // first_beat[95], read_address[117:96], zero fill [119:118]
    input  wire logic [119:0]  s_axis_tdata,
    // opcode[2:0], byte_valid[3]
    input  wire logic [3:0]    s_axis_tuser,
    // last_beat
    input  wire logic          s_axis_tlast,
    // Result words
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // ready_frame_id[31:0], frame_length[54:32], read_data[62:55], zero fill [63]
    output logic [63:0]        m_axis_tdata,
    // status[2:0]
    output logic [2:0]         m_axis_tuser
);

    logic                          in_take;
    logic                          q_room;
    rfr_pkg::wr_req_t              wr;
    rfr_pkg::rd_req_t              rd;
    logic [rfr_pkg::BYTE_W-1:0]    rd_data;
    logic                          res_valid_reg;
    rfr_pkg::res_t                 res_reg;
    rfr_pkg::out_word_t            push_word;
    rfr_pkg::out_word_t            pop_word;

    assign s_axis_tready = q_room;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    rfr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_take       (in_take),
        .opcode        (s_axis_tuser[2:0]),
        .magic         (s_axis_tdata[31:0]),
        .frame_id      (s_axis_tdata[63:32]),
        .packet_len    (s_axis_tdata[86:64]),
        .data_byte     (s_axis_tdata[94:87]),
        .byte_valid    (s_axis_tuser[3]),
        .first_beat    (s_axis_tdata[95]),
        .last_beat     (s_axis_tlast),
        .read_address  (s_axis_tdata[117:96]),
        .wr            (wr),
        .rd            (rd),
        .res_valid_reg (res_valid_reg),
        .res_reg       (res_reg)
    );

    rfr_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Merge the store byte into the result
    always_comb begin
        push_word.status = res_reg.status;
        push_word.rid    = res_reg.rid;
        push_word.flen   = res_reg.flen;
        push_word.rdata  = res_reg.use_rdata ? rd_data : '0;
    end

    rfr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid_reg),
        .push_word (push_word),
        .room      (q_room),
        .pop_valid (m_axis_tvalid),
        .pop_word  (pop_word),
        .pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, pop_word.rdata, pop_word.flen, pop_word.rid};
    assign m_axis_tuser = pop_word.status;

endmodule
`default_nettype wire
